[rtl/core/ecu_identity_sync_supervisor_assert.svh]
// assertion macros for the identity sync supervisor checker
`ifndef ECU_IDENTITY_SYNC_SUPERVISOR_ASSERT_SVH
`define ECU_IDENTITY_SYNC_SUPERVISOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define ISS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ecu identity sync supervisor assertion failed");

// consequent checked in the cycle after the antecedent
`define ISS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ecu identity sync supervisor assertion failed");

`endif

[rtl/core/ecu_iss_pkg.sv]
`default_nettype none

package ecu_iss_pkg;

   // register indexes of the write port
   localparam logic [2:0] CSR_DIAG_MODE     = 3'd0;
   localparam logic [2:0] CSR_PARAM_CHECK   = 3'd1;
   localparam logic [2:0] CSR_DIAG_TRIGGER  = 3'd2;
   localparam logic [2:0] CSR_SERIAL_INIT   = 3'd3;
   localparam logic [2:0] CSR_TYPE_INIT     = 3'd4;
   localparam logic [2:0] CSR_HOURS_INIT    = 3'd5;

   // reset values
   localparam logic [31:0] SERIAL_RESET = 32'hFFFF_FFFF;
   localparam logic [15:0] TYPE_RESET   = 16'hFFFF;
   localparam logic [31:0] HOURS_RESET  = 32'h0000_0000;
   localparam logic [4:0]  RESET_PERIOD = 5'd20;

   // invalid markers
   localparam logic [31:0] INVALID32 = 32'hFFFF_FFFF;
   localparam logic [15:0] INVALID16 = 16'hFFFF;

   typedef struct packed {
      logic        rx1_event;
      logic        rx2_event;
      logic        rx_ident1_event;
      logic        diag_request;
      logic [31:0] peer1_serial;
      logic [15:0] peer1_type;
      logic [31:0] peer1_hours;
      logic [31:0] peer2_serial;
      logic [15:0] peer2_type;
      logic [31:0] peer2_hours;
   } req_word_type;

   typedef struct packed {
      logic        tx_request;
      logic        peer1_timed_out;
      logic        peer2_timed_out;
      logic        peer1_slow;
      logic [31:0] own_serial;
      logic [15:0] own_type;
      logic [31:0] own_hours;
      logic [4:0]  tx_period;
   } rsp_word_type;

   // which transmit period is in force
   typedef enum logic [1:0] {
      PER_RESET,
      PER_SYNC,
      PER_UNSYNC,
      PER_SLOW
   } period_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_MATCH,
      ST_MERGE
   } ctrl_state_type;

   typedef struct packed {
      logic load;   // capture the input word
      logic count;  // tick, silence, timeout and debounce update
      logic match;  // identity compares, validity checks and partial maxima
      logic merge;  // identity rules, period select, result load
   } dp_cmd_type;

endpackage

`default_nettype wire

[rtl/core/ecu_iss_ctrl.sv]
`default_nettype none

module ecu_iss_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output ecu_iss_pkg::dp_cmd_type cmd
);
   import ecu_iss_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register may be reloaded once its word is gone
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = ST_MATCH;
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_MERGE;
         end
         ST_MERGE: begin
            if (out_free) begin
               cmd.merge = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.merge ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/core/ecu_iss_datapath.sv]
`default_nettype none

module ecu_iss_datapath #(
   parameter int TIMEOUT_TICKS  = 50,
   parameter int SYNC_PERIOD    = 10,
   parameter int UNSYNC_PERIOD  = 20,
   parameter int SLOW_PERIOD    = 15,
   parameter int RATE_TOLERANCE = 1,
   parameter int DEBOUNCE_COUNT = 3
) (
   input  wire                       clock,
   input  wire                       reset,
   input  ecu_iss_pkg::dp_cmd_type   cmd,
   input  ecu_iss_pkg::req_word_type req_data,
   input  wire                       csr_write,
   input  wire  [2:0]                csr_index,
   input  wire  [31:0]               csr_data,
   output ecu_iss_pkg::rsp_word_type rsp_data
);
   import ecu_iss_pkg::*;

   localparam logic [4:0] SYNC_LAST   = 5'(SYNC_PERIOD - 1);
   localparam logic [4:0] UNSYNC_LAST = 5'(UNSYNC_PERIOD - 1);
   localparam logic [4:0] SLOW_LAST   = 5'(SLOW_PERIOD - 1);
   localparam logic [4:0] RESET_LAST  = RESET_PERIOD - 5'd1;
   localparam int         FAST_LIMIT  = SYNC_PERIOD + RATE_TOLERANCE;
   localparam int         NORMAL_MIN  = UNSYNC_PERIOD - RATE_TOLERANCE;
   localparam int         SLOW_MIN    = SLOW_PERIOD - RATE_TOLERANCE;

   // residue counter: tick count modulo one period, cleared on tick wrap
   function automatic logic [4:0] next_res(input logic [4:0] r, input logic [4:0] last,
                                           input logic wrap);
      logic [4:0] n;
      n = (wrap || r == last) ? 5'd0 : r + 5'd1;
      return n;
   endfunction

   function automatic logic [4:0] period_value(input period_sel_type sel);
      logic [4:0] v;
      case (sel)
         PER_SYNC:   v = 5'(SYNC_PERIOD);
         PER_UNSYNC: v = 5'(UNSYNC_PERIOD);
         PER_SLOW:   v = 5'(SLOW_PERIOD);
         default:    v = RESET_PERIOD;
      endcase
      return v;
   endfunction

   // configuration
   logic diag_mode_ff, param_check_ff, diag_trigger_ff;

   // input word
   req_word_type in_ff;

   // count stage state
   logic [31:0]    tick_ff, tick_in;
   logic [4:0]     res_sync_ff, res_sync_in;
   logic [4:0]     res_unsync_ff, res_unsync_in;
   logic [4:0]     res_slow_ff, res_slow_in;
   logic [4:0]     res_reset_ff, res_reset_in;
   period_sel_type period_sel_ff, period_sel_in;
   logic [5:0]     silence1_ff, silence1_in;
   logic [5:0]     silence2_ff, silence2_in;
   logic           timeout1_ff, timeout1_in;
   logic           timeout2_ff, timeout2_in;
   logic           slow1_ff, slow1_in;
   logic [1:0]     debounce1_ff, debounce1_in;
   logic           tx_ff, tx_in;
   logic           wrap;

   // match stage
   logic        m1_ff, m1_in, m2_ff, m2_in, peq_ff, peq_in;
   logic        v1_ff, v1_in, v2_ff, v2_in;
   logic [31:0] max_l1_ff, max_l1_in, max_l2_ff, max_l2_in;

   // identity
   logic [31:0] local_serial_ff, local_serial_in;
   logic [15:0] local_type_ff, local_type_in;
   logic [31:0] local_hours_ff, local_hours_in;
   logic [31:0] max_all;
   logic        f1, f2;

   rsp_word_type rsp_ff, rsp_in;

   // ---- count stage ----
   assign tick_in       = tick_ff + 32'd1;
   assign wrap          = (tick_in == 32'd0);
   assign res_sync_in   = next_res(res_sync_ff, SYNC_LAST, wrap);
   assign res_unsync_in = next_res(res_unsync_ff, UNSYNC_LAST, wrap);
   assign res_slow_in   = next_res(res_slow_ff, SLOW_LAST, wrap);
   assign res_reset_in  = next_res(res_reset_ff, RESET_LAST, wrap);

   always_comb begin
      case (period_sel_ff)
         PER_SYNC:   tx_in = (res_sync_in == 5'd0);
         PER_UNSYNC: tx_in = (res_unsync_in == 5'd0);
         PER_SLOW:   tx_in = (res_slow_in == 5'd0);
         default:    tx_in = (res_reset_in == 5'd0);
      endcase
   end

   always_comb begin
      silence1_in  = silence1_ff;
      timeout1_in  = timeout1_ff;
      slow1_in     = slow1_ff;
      debounce1_in = debounce1_ff;
      if (in_ff.rx1_event) begin
         timeout1_in = 1'b0;
         silence1_in = 6'd0;
         if (diag_mode_ff && param_check_ff) begin
            if (int'(silence1_ff) >= NORMAL_MIN || int'(silence1_ff) <= FAST_LIMIT) begin
               slow1_in     = 1'b0;
               debounce1_in = 2'd0;
            end else if (int'(silence1_ff) >= SLOW_MIN) begin
               if (int'(debounce1_ff) < DEBOUNCE_COUNT) begin
                  debounce1_in = debounce1_ff + 2'd1;
               end else begin
                  slow1_in = 1'b1;
               end
            end
         end
      end else if (int'(silence1_ff) >= TIMEOUT_TICKS) begin
         timeout1_in = 1'b1;
      end else begin
         silence1_in = silence1_ff + 6'd1;
      end
   end

   always_comb begin
      silence2_in = silence2_ff;
      timeout2_in = timeout2_ff;
      if (in_ff.rx2_event) begin
         // diag mode leaves the peer 2 timeout flag alone
         if (!diag_mode_ff) begin
            timeout2_in = 1'b0;
         end
         silence2_in = 6'd0;
      end else if (int'(silence2_ff) >= TIMEOUT_TICKS) begin
         timeout2_in = 1'b1;
      end else begin
         silence2_in = silence2_ff + 6'd1;
      end
   end

   // ---- match stage ----
   assign m1_in  = (local_serial_ff == in_ff.peer1_serial) && (local_type_ff == in_ff.peer1_type);
   assign m2_in  = (local_serial_ff == in_ff.peer2_serial) && (local_type_ff == in_ff.peer2_type);
   assign peq_in = (in_ff.peer1_serial == in_ff.peer2_serial)
                   && (in_ff.peer1_type == in_ff.peer2_type);
   assign v1_in  = (in_ff.peer1_serial != INVALID32) && (in_ff.peer1_type != INVALID16)
                   && (in_ff.peer1_hours != INVALID32);
   assign v2_in  = (in_ff.peer2_serial != INVALID32) && (in_ff.peer2_type != INVALID16)
                   && (in_ff.peer2_hours != INVALID32);
   assign max_l1_in = (in_ff.peer1_hours > local_hours_ff) ? in_ff.peer1_hours : local_hours_ff;
   assign max_l2_in = (in_ff.peer2_hours > local_hours_ff) ? in_ff.peer2_hours : local_hours_ff;

   // ---- merge stage ----
   assign max_all = (in_ff.peer2_hours > max_l1_ff) ? in_ff.peer2_hours : max_l1_ff;
   assign f1      = !timeout1_ff;
   assign f2      = !timeout2_ff;

   always_comb begin
      local_serial_in = local_serial_ff;
      local_type_in   = local_type_ff;
      local_hours_in  = local_hours_ff;
      period_sel_in   = PER_UNSYNC;
      if (!diag_mode_ff) begin
         if (m1_ff && peq_ff && f1 && f2 && v1_ff && v2_ff) begin
            local_hours_in = max_all;
            period_sel_in  = PER_SYNC;
         end else if (m1_ff && !peq_ff && f1 && v1_ff) begin
            local_hours_in = max_l1_ff;
            period_sel_in  = PER_SYNC;
         end else if (m2_ff && !peq_ff && f2 && v2_ff) begin
            local_hours_in = max_l2_ff;
            period_sel_in  = PER_SYNC;
         end else if (!m1_ff && peq_ff && f1 && f2) begin
            // adopted whole, valid or not
            local_serial_in = in_ff.peer1_serial;
            local_type_in   = in_ff.peer1_type;
            local_hours_in  = in_ff.peer1_hours;
            period_sel_in   = PER_SYNC;
         end
      end else begin
         if (slow1_ff && in_ff.rx_ident1_event && v1_ff) begin
            local_serial_in = in_ff.peer1_serial;
            local_type_in   = in_ff.peer1_type;
            local_hours_in  = in_ff.peer1_hours;
         end
         if (in_ff.diag_request && diag_trigger_ff) begin
            period_sel_in = PER_SLOW;
         end
      end
   end

   always_comb begin
      rsp_in.tx_request      = tx_ff;
      rsp_in.peer1_timed_out = timeout1_ff;
      rsp_in.peer2_timed_out = timeout2_ff;
      rsp_in.peer1_slow      = slow1_ff;
      rsp_in.own_serial      = local_serial_in;
      rsp_in.own_type        = local_type_in;
      rsp_in.own_hours       = local_hours_in;
      rsp_in.tx_period       = period_value(period_sel_in);
   end

   // control state, counters, flags and identity
   always_ff @(posedge clock) begin
      if (reset) begin
         diag_mode_ff    <= 1'b0;
         param_check_ff  <= 1'b0;
         diag_trigger_ff <= 1'b0;
         tick_ff         <= 32'd0;
         res_sync_ff     <= 5'd0;
         res_unsync_ff   <= 5'd0;
         res_slow_ff     <= 5'd0;
         res_reset_ff    <= 5'd0;
         period_sel_ff   <= PER_RESET;
         silence1_ff     <= 6'd0;
         silence2_ff     <= 6'd0;
         timeout1_ff     <= 1'b1;
         timeout2_ff     <= 1'b1;
         slow1_ff        <= 1'b0;
         debounce1_ff    <= 2'd0;
         local_serial_ff <= SERIAL_RESET;
         local_type_ff   <= TYPE_RESET;
         local_hours_ff  <= HOURS_RESET;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DIAG_MODE:    diag_mode_ff    <= csr_data[0];
               CSR_PARAM_CHECK:  param_check_ff  <= csr_data[0];
               CSR_DIAG_TRIGGER: diag_trigger_ff <= csr_data[0];
               CSR_SERIAL_INIT:  local_serial_ff <= csr_data;
               CSR_TYPE_INIT:    local_type_ff   <= csr_data[15:0];
               CSR_HOURS_INIT:   local_hours_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.count) begin
            tick_ff       <= tick_in;
            res_sync_ff   <= res_sync_in;
            res_unsync_ff <= res_unsync_in;
            res_slow_ff   <= res_slow_in;
            res_reset_ff  <= res_reset_in;
            silence1_ff   <= silence1_in;
            silence2_ff   <= silence2_in;
            timeout1_ff   <= timeout1_in;
            timeout2_ff   <= timeout2_in;
            slow1_ff      <= slow1_in;
            debounce1_ff  <= debounce1_in;
         end
         if (cmd.merge) begin
            period_sel_ff   <= period_sel_in;
            local_serial_ff <= local_serial_in;
            local_type_ff   <= local_type_in;
            local_hours_ff  <= local_hours_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_data;
      end
      if (cmd.count) begin
         tx_ff <= tx_in;
      end
      if (cmd.match) begin
         m1_ff     <= m1_in;
         m2_ff     <= m2_in;
         peq_ff    <= peq_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         max_l1_ff <= max_l1_in;
         max_l2_ff <= max_l2_in;
      end
      if (cmd.merge) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/ecu_identity_sync_supervisor.sv]
`default_nettype none
// channel   direction  handshake                  word
// req_      in         req_valid / req_stall      ecu_iss_pkg::req_word_type, one 100 ms tick
// rsp_      out        rsp_valid / rsp_stall      ecu_iss_pkg::rsp_word_type, one per tick
// csr_      in         csr_write, csr_index       csr_data, no wait, no read-back
//
// each word passes four steps: capture, counter update, identity compare, merge
// the merge step waits while the previous result word is still stalled at the output
// the next word is taken in the cycle after the merge, so a word is not taken before the last is through
// reset (synchronous, active high) clears counters, sets the timeout flags and
// loads the reset identity; a stalled result holds its word and valid until taken

module ecu_identity_sync_supervisor #(
   parameter int TIMEOUT_TICKS  = 50,
   parameter int SYNC_PERIOD    = 10,
   parameter int UNSYNC_PERIOD  = 20,
   parameter int SLOW_PERIOD    = 15,
   parameter int RATE_TOLERANCE = 1,
   parameter int DEBOUNCE_COUNT = 3
) (
   input  wire                       clock,
   input  wire                       reset,
   // tick word in
   input  wire                       req_valid,
   output logic                      req_stall,
   input  ecu_iss_pkg::req_word_type req_data,
   // result word out
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output ecu_iss_pkg::rsp_word_type rsp_data,
   // register writes
   input  wire                       csr_write,
   input  wire  [2:0]                csr_index,
   input  wire  [31:0]               csr_data
);
   import ecu_iss_pkg::*;

   dp_cmd_type cmd;

   // sequencer: one word at a time through the four steps
   ecu_iss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // counters, flags, identity merge and the output word register;
   // the transmit check keeps tick residues per period instead of dividing
   ecu_iss_datapath #(
      .TIMEOUT_TICKS  (TIMEOUT_TICKS),
      .SYNC_PERIOD    (SYNC_PERIOD),
      .UNSYNC_PERIOD  (UNSYNC_PERIOD),
      .SLOW_PERIOD    (SLOW_PERIOD),
      .RATE_TOLERANCE (RATE_TOLERANCE),
      .DEBOUNCE_COUNT (DEBOUNCE_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/core/ecu_iss_checker.sv]
`default_nettype none
`include "ecu_identity_sync_supervisor_assert.svh"

module ecu_iss_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_stall,
   input wire                       rsp_valid,
   input wire                       rsp_stall,
   input ecu_iss_pkg::rsp_word_type rsp_data
);
   import ecu_iss_pkg::*;

   // a stalled result keeps valid and word
   `ISS_ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ISS_ASSERT_NEXT(a_rsp_hold_word, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   // busy once a word is taken
   `ISS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   // a new result only comes out of the merge step
   `ISS_ASSERT_SAME(a_result_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))
   // a selected period is never zero
   `ISS_ASSERT_SAME(a_period_nonzero, clock, reset, rsp_valid, rsp_data.tx_period != 5'd0)

endmodule

bind ecu_identity_sync_supervisor ecu_iss_checker u_checker (.*);

`default_nettype wire
